[hw/rtl/rtwdf_pkg.sv]
// Package for the tag write downlink framer: beat types, segment kinds,
// register indexes, timing defaults and the command frame builder.
// No dependencies; every RTL file of the block refers to it by scoped names.
package rtwdf_pkg;

    localparam int FRAME_BITS = 57;
    localparam int NUM_SEGS   = 60;
    localparam int SEG_CNT_W  = $clog2(NUM_SEGS);

    localparam logic [SEG_CNT_W-1:0] SEG_POWER_IDX = SEG_CNT_W'(0);
    localparam logic [SEG_CNT_W-1:0] SEG_STOP_IDX  = SEG_CNT_W'(1);
    localparam logic [SEG_CNT_W-1:0] SEG_LAST_IDX  = SEG_CNT_W'(NUM_SEGS - 1);

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_OPCODE    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_BIT_ON_US   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_BIT_OFF_US = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_BIT_ON_US  = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_GAP_OFF_US = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_GAP_ON_US  = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_POWER_UP_US     = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROGRAM_WAIT_US = 8'd7;

    localparam logic [2:0]  RST_WRITE_OPCODE    = 3'd2;
    localparam logic [11:0] RST_ONE_BIT_ON_US   = 12'd256;
    localparam logic [11:0] RST_ZERO_BIT_OFF_US = 12'd184;
    localparam logic [11:0] RST_ZERO_BIT_ON_US  = 12'd144;
    localparam logic [11:0] RST_STOP_GAP_OFF_US = 12'd440;
    localparam logic [11:0] RST_STOP_GAP_ON_US  = 12'd144;
    localparam logic [15:0] RST_POWER_UP_US     = 16'd8000;
    localparam logic [15:0] RST_PROGRAM_WAIT_US = 16'd10820;

    typedef enum logic [1:0] {
        SEG_POWER_UP   = 2'd0,
        SEG_FIELD_STOP = 2'd1,
        SEG_DATA_BIT   = 2'd2,
        SEG_PROGRAM    = 2'd3
    } seg_kind_t;

    typedef struct packed {
        logic [3:0]  word_address;
        logic [31:0] word_value;
    } in_beat_t;

    typedef struct packed {
        seg_kind_t   segment_kind;
        logic        bit_value;
        logic [11:0] off_time_us;
        logic [15:0] on_time_us;
        logic        last;
    } out_beat_t;

    typedef struct packed {
        logic load;
        logic shift;
    } chain_ctrl_t;

    // Bit k of the result is the k-th bit sent on the air.
    function automatic logic [FRAME_BITS-1:0] build_frame(
        input logic [2:0]  opcode,
        input logic [3:0]  addr,
        input logic [31:0] data
    );
        logic [FRAME_BITS-1:0] f;
        f = '0;
        f[0]     = 1'b0;
        f[3:1]   = opcode;
        f[4]     = ^opcode;
        f[8:5]   = addr;
        f[10:9]  = 2'b00;
        f[11]    = ^addr;
        for (int b = 0; b < 4; b++) begin
            f[12 + 9*b +: 8] = data[8*b +: 8];
            f[20 + 9*b]      = ^data[8*b +: 8];
        end
        for (int c = 0; c < 8; c++) begin
            f[48 + c] = data[c] ^ data[8 + c] ^ data[16 + c] ^ data[24 + c];
        end
        f[56] = 1'b0;
        return f;
    endfunction

endpackage

[hw/rtl/rtwdf_bit_cell.sv]
// One storage cell of the command bit chain.
// Loads its frame bit or takes its neighbor's bit; uses rtwdf_pkg.
module rtwdf_bit_cell (
    input  logic                  aclk,
    input  rtwdf_pkg::chain_ctrl_t ctrl,
    input  logic                  load_bit,
    input  logic                  next_bit,
    output logic                  bit_q
);

    logic bit_reg;
    logic bit_next;

    always_comb begin
        priority if (ctrl.load) begin
            bit_next = load_bit;
        end else if (ctrl.shift) begin
            bit_next = next_bit;
        end else begin
            bit_next = bit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        bit_reg <= bit_next;
    end

    assign bit_q = bit_reg;

endmodule

[hw/rtl/rtwdf_bit_chain.sv]
// Row of bit cells holding the 57-bit command frame; the head cell is sent next.
// Depends on rtwdf_pkg and rtwdf_bit_cell.
module rtwdf_bit_chain (
    input  logic                                aclk,
    input  rtwdf_pkg::chain_ctrl_t              ctrl,
    input  logic [rtwdf_pkg::FRAME_BITS-1:0]    frame,
    output logic                                head_bit
);

    logic [rtwdf_pkg::FRAME_BITS:0] cell_q;

    assign cell_q[rtwdf_pkg::FRAME_BITS] = 1'b0;

    for (genvar i = 0; i < rtwdf_pkg::FRAME_BITS; i++) begin : g_cell
        rtwdf_bit_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .load_bit (frame[i]),
            .next_bit (cell_q[i+1]),
            .bit_q    (cell_q[i])
        );
    end

    assign head_bit = cell_q[0];

endmodule

[hw/rtl/rfid_tag_write_downlink_framer.sv]
// Top level of the tag write downlink framer: configuration registers, segment
// sequencer and output register. Depends on rtwdf_pkg and rtwdf_bit_chain.
//
// Usage: each beat on the s_ channel is one write request (word address and
// data word). For it the block sends 60 segment beats on the m_ channel: the
// power-up wait, the field stop, 57 command bits and the programming wait,
// which carries last. The configuration port writes one timing or opcode
// register per cycle with cfg_wr_en; indexes of 8 and above are ignored, and
// registers should only be written while no request is in flight.
// An accepted request sets busy and the counter; each segment then passes the output register.
// Throughput: one segment per cycle while the output is not stalled; the next
// request is accepted in the cycle the previous program-wait segment is
// produced. The 57-cell shift chain advances once per data-bit segment.
// Reset (aresetn low, synchronous) restores default timings and drops all
// work in flight. While a beat waits with m_ready low the output register holds
// it and the sequencer and chain stop until it is taken.
module rfid_tag_write_downlink_framer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [rtwdf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rtwdf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  rtwdf_pkg::in_beat_t                  s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output rtwdf_pkg::out_beat_t                 m_data
);

    logic [2:0]  write_opcode_reg;
    logic [11:0] one_bit_on_reg;
    logic [11:0] zero_bit_off_reg;
    logic [11:0] zero_bit_on_reg;
    logic [11:0] stop_gap_off_reg;
    logic [11:0] stop_gap_on_reg;
    logic [15:0] power_up_reg;
    logic [15:0] program_wait_reg;

    logic                              busy_reg, busy_next;
    logic [rtwdf_pkg::SEG_CNT_W-1:0]   seg_cnt_reg, seg_cnt_next;
    logic                              m_valid_reg, m_valid_next;
    rtwdf_pkg::out_beat_t              m_data_reg, m_data_next;

    logic                              emit;
    logic                              emit_last;
    logic                              accept;
    logic                              head_bit;
    rtwdf_pkg::chain_ctrl_t            chain_ctrl;
    logic [rtwdf_pkg::FRAME_BITS-1:0]  frame;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_opcode_reg <= rtwdf_pkg::RST_WRITE_OPCODE;
            one_bit_on_reg   <= rtwdf_pkg::RST_ONE_BIT_ON_US;
            zero_bit_off_reg <= rtwdf_pkg::RST_ZERO_BIT_OFF_US;
            zero_bit_on_reg  <= rtwdf_pkg::RST_ZERO_BIT_ON_US;
            stop_gap_off_reg <= rtwdf_pkg::RST_STOP_GAP_OFF_US;
            stop_gap_on_reg  <= rtwdf_pkg::RST_STOP_GAP_ON_US;
            power_up_reg     <= rtwdf_pkg::RST_POWER_UP_US;
            program_wait_reg <= rtwdf_pkg::RST_PROGRAM_WAIT_US;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rtwdf_pkg::CFG_WRITE_OPCODE:    write_opcode_reg <= cfg_wdata[2:0];
                rtwdf_pkg::CFG_ONE_BIT_ON_US:   one_bit_on_reg   <= cfg_wdata[11:0];
                rtwdf_pkg::CFG_ZERO_BIT_OFF_US: zero_bit_off_reg <= cfg_wdata[11:0];
                rtwdf_pkg::CFG_ZERO_BIT_ON_US:  zero_bit_on_reg  <= cfg_wdata[11:0];
                rtwdf_pkg::CFG_STOP_GAP_OFF_US: stop_gap_off_reg <= cfg_wdata[11:0];
                rtwdf_pkg::CFG_STOP_GAP_ON_US:  stop_gap_on_reg  <= cfg_wdata[11:0];
                rtwdf_pkg::CFG_POWER_UP_US:     power_up_reg     <= cfg_wdata[15:0];
                rtwdf_pkg::CFG_PROGRAM_WAIT_US: program_wait_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign emit      = busy_reg && (!m_valid_reg || m_ready);
    assign emit_last = emit && (seg_cnt_reg == rtwdf_pkg::SEG_LAST_IDX);
    assign s_ready   = !busy_reg || emit_last;
    assign accept    = s_valid && s_ready;

    assign frame = rtwdf_pkg::build_frame(write_opcode_reg, s_data.word_address,
                                          s_data.word_value);

    always_comb begin
        chain_ctrl.load  = accept;
        chain_ctrl.shift = emit && (seg_cnt_reg != rtwdf_pkg::SEG_POWER_IDX)
                                && (seg_cnt_reg != rtwdf_pkg::SEG_STOP_IDX)
                                && (seg_cnt_reg != rtwdf_pkg::SEG_LAST_IDX);
    end

    rtwdf_bit_chain u_chain (
        .aclk     (aclk),
        .ctrl     (chain_ctrl),
        .frame    (frame),
        .head_bit (head_bit)
    );

    always_comb begin
        busy_next    = busy_reg;
        seg_cnt_next = seg_cnt_reg;
        if (accept) begin
            busy_next    = 1'b1;
            seg_cnt_next = '0;
        end else if (emit_last) begin
            busy_next    = 1'b0;
        end else if (emit) begin
            seg_cnt_next = seg_cnt_reg + 1'b1;
        end
    end

    always_comb begin
        m_data_next = m_data_reg;
        if (emit) begin
            m_data_next.last = 1'b0;
            priority if (seg_cnt_reg == rtwdf_pkg::SEG_POWER_IDX) begin
                m_data_next.segment_kind = rtwdf_pkg::SEG_POWER_UP;
                m_data_next.bit_value    = 1'b0;
                m_data_next.off_time_us  = '0;
                m_data_next.on_time_us   = power_up_reg;
            end else if (seg_cnt_reg == rtwdf_pkg::SEG_STOP_IDX) begin
                m_data_next.segment_kind = rtwdf_pkg::SEG_FIELD_STOP;
                m_data_next.bit_value    = 1'b0;
                m_data_next.off_time_us  = stop_gap_off_reg;
                m_data_next.on_time_us   = {4'd0, stop_gap_on_reg};
            end else if (seg_cnt_reg == rtwdf_pkg::SEG_LAST_IDX) begin
                m_data_next.segment_kind = rtwdf_pkg::SEG_PROGRAM;
                m_data_next.bit_value    = 1'b0;
                m_data_next.off_time_us  = '0;
                m_data_next.on_time_us   = program_wait_reg;
                m_data_next.last         = 1'b1;
            end else begin
                m_data_next.segment_kind = rtwdf_pkg::SEG_DATA_BIT;
                m_data_next.bit_value    = head_bit;
                m_data_next.off_time_us  = head_bit ? 12'd0 : zero_bit_off_reg;
                m_data_next.on_time_us   = head_bit ? {4'd0, one_bit_on_reg}
                                                    : {4'd0, zero_bit_on_reg};
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            seg_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            seg_cnt_reg <= seg_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> busy_reg && (seg_cnt_reg == '0))
        else $error("accepted request did not restart the sequencer");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> seg_cnt_reg <= rtwdf_pkg::SEG_LAST_IDX)
        else $error("segment counter out of range");

    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |-> m_data.segment_kind == rtwdf_pkg::SEG_PROGRAM)
        else $error("last flag on a segment other than program wait");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_last && !s_valid |=> !busy_reg)
        else $error("sequencer stayed busy after the final segment");

    a_no_accept_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !emit_last |-> !s_ready)
        else $error("request accepted while a frame is in progress");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the tag write downlink framer: sends write requests
// under several idling mixes and compares every segment beat with a predicted frame.
// Depends on rtwdf_pkg and the rfid_tag_write_downlink_framer top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [rtwdf_pkg::CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [rtwdf_pkg::CFG_DATA_W-1:0]  cfg_data_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    cfg_index_t             cfg_index;
    cfg_data_t              cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    rtwdf_pkg::in_beat_t    s_data;
    logic                   m_valid;
    logic                   m_ready;
    rtwdf_pkg::out_beat_t   m_data;

    logic [2:0]  cur_opcode;
    logic [11:0] cur_one_on;
    logic [11:0] cur_zero_off;
    logic [11:0] cur_zero_on;
    logic [11:0] cur_stop_off;
    logic [11:0] cur_stop_on;
    logic [15:0] cur_power_on;
    logic [15:0] cur_program_on;

    rtwdf_pkg::out_beat_t segments_due[$];
    int        fail_count     = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    rfid_tag_write_downlink_framer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(36_000_000);
        $display("FAIL rfid_tag_write_downlink_framer");
        $finish;
    end

    initial begin
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic rtwdf_pkg::out_beat_t make_segment(rtwdf_pkg::seg_kind_t kind,
                                                          logic bval,
                                                          logic [11:0] off_us,
                                                          logic [15:0] on_us,
                                                          logic is_last);
        rtwdf_pkg::out_beat_t seg;
        seg.segment_kind = kind;
        seg.bit_value    = bval;
        seg.off_time_us  = off_us;
        seg.on_time_us   = on_us;
        seg.last         = is_last;
        return seg;
    endfunction

    // Builds the on-air bit sequence of one write command and queues its segments.
    task automatic expect_segments(input rtwdf_pkg::in_beat_t req);
        bit         air[$];
        logic [7:0] octet;
        logic [7:0] columns;
        air.push_back(1'b0);
        for (int i = 0; i < 3; i++) air.push_back(cur_opcode[i]);
        air.push_back(^cur_opcode);
        for (int i = 0; i < 4; i++) air.push_back(req.word_address[i]);
        air.push_back(1'b0);
        air.push_back(1'b0);
        air.push_back(^req.word_address);
        columns = '0;
        for (int b = 0; b < 4; b++) begin
            octet = req.word_value[8*b +: 8];
            for (int j = 0; j < 8; j++) air.push_back(octet[j]);
            air.push_back(^octet);
            columns = columns ^ octet;
        end
        for (int j = 0; j < 8; j++) air.push_back(columns[j]);
        air.push_back(1'b0);
        segments_due.push_back(make_segment(rtwdf_pkg::SEG_POWER_UP, 1'b0, 12'd0,
                                            cur_power_on, 1'b0));
        segments_due.push_back(make_segment(rtwdf_pkg::SEG_FIELD_STOP, 1'b0, cur_stop_off,
                                            {4'd0, cur_stop_on}, 1'b0));
        foreach (air[k]) begin
            if (air[k]) begin
                segments_due.push_back(make_segment(rtwdf_pkg::SEG_DATA_BIT, 1'b1, 12'd0,
                                                    {4'd0, cur_one_on}, 1'b0));
            end else begin
                segments_due.push_back(make_segment(rtwdf_pkg::SEG_DATA_BIT, 1'b0,
                                                    cur_zero_off,
                                                    {4'd0, cur_zero_on}, 1'b0));
            end
        end
        segments_due.push_back(make_segment(rtwdf_pkg::SEG_PROGRAM, 1'b0, 12'd0,
                                            cur_program_on, 1'b1));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (segments_due.size() == 0) begin
                fail_count++;
                if (fail_count < 100) $error("segment beat with none expected");
            end else begin
                rtwdf_pkg::out_beat_t exp_seg;
                exp_seg = segments_due.pop_front();
                if (m_data.segment_kind !== exp_seg.segment_kind) begin
                    fail_count++;
                    if (fail_count < 100) $error("segment_kind expected %0d got %0d",
                                                 exp_seg.segment_kind, m_data.segment_kind);
                end
                if (m_data.bit_value !== exp_seg.bit_value) begin
                    fail_count++;
                    if (fail_count < 100) $error("bit_value expected %0d got %0d",
                                                 exp_seg.bit_value, m_data.bit_value);
                end
                if (m_data.off_time_us !== exp_seg.off_time_us) begin
                    fail_count++;
                    if (fail_count < 100) $error("off_time_us expected %0d got %0d",
                                                 exp_seg.off_time_us, m_data.off_time_us);
                end
                if (m_data.on_time_us !== exp_seg.on_time_us) begin
                    fail_count++;
                    if (fail_count < 100) $error("on_time_us expected %0d got %0d",
                                                 exp_seg.on_time_us, m_data.on_time_us);
                end
                if (m_data.last !== exp_seg.last) begin
                    fail_count++;
                    if (fail_count < 100) $error("last expected %0d got %0d",
                                                 exp_seg.last, m_data.last);
                end
            end
        end
    end

    // All tasks below are entered and left at a falling clock edge.
    task automatic cfg_write(input cfg_index_t idx, input cfg_data_t val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        unique case (idx)
            rtwdf_pkg::CFG_WRITE_OPCODE:    cur_opcode     = val[2:0];
            rtwdf_pkg::CFG_ONE_BIT_ON_US:   cur_one_on     = val[11:0];
            rtwdf_pkg::CFG_ZERO_BIT_OFF_US: cur_zero_off   = val[11:0];
            rtwdf_pkg::CFG_ZERO_BIT_ON_US:  cur_zero_on    = val[11:0];
            rtwdf_pkg::CFG_STOP_GAP_OFF_US: cur_stop_off   = val[11:0];
            rtwdf_pkg::CFG_STOP_GAP_ON_US:  cur_stop_on    = val[11:0];
            rtwdf_pkg::CFG_POWER_UP_US:     cur_power_on   = val;
            rtwdf_pkg::CFG_PROGRAM_WAIT_US: cur_program_on = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic cfg_write_timings(input cfg_data_t val);
        for (int i = 1; i < 8; i++) cfg_write(cfg_index_t'(i), val);
    endtask

    task automatic send_request(input logic [3:0] addr, input logic [31:0] value);
        rtwdf_pkg::in_beat_t req;
        req.word_address = addr;
        req.word_value   = value;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        expect_segments(req);
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (segments_due.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_word_value();
        unique case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << $urandom_range(31);
            3:       return ~(32'h1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    function automatic cfg_data_t pick_reg_value();
        unique case ($urandom_range(5))
            0:       return '0;
            1:       return 16'h0FFF;
            2:       return 16'hFFFF;
            default: return cfg_data_t'($urandom_range(65535));
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(4'h0, 32'h0000_0000);
        send_request(4'hF, 32'hFFFF_FFFF);
        send_request(4'hA, 32'hA5A5_5A5A);
        send_request(4'h5, 32'h0123_4567);
        wait_drain();
    endtask

    task automatic test_every_opcode();
        for (int op = 0; op < 8; op++) begin
            cfg_write(rtwdf_pkg::CFG_WRITE_OPCODE, cfg_data_t'(op));
            send_request(4'(op * 2 + 1), $urandom);
            wait_drain();
        end
    endtask

    task automatic test_timing_extremes();
        cfg_write(rtwdf_pkg::CFG_WRITE_OPCODE, 16'd7);
        cfg_write(rtwdf_pkg::CFG_ONE_BIT_ON_US, 16'd4095);
        cfg_write(rtwdf_pkg::CFG_ZERO_BIT_OFF_US, 16'd4095);
        cfg_write(rtwdf_pkg::CFG_ZERO_BIT_ON_US, 16'd4095);
        cfg_write(rtwdf_pkg::CFG_STOP_GAP_OFF_US, 16'd4095);
        cfg_write(rtwdf_pkg::CFG_STOP_GAP_ON_US, 16'd4095);
        cfg_write(rtwdf_pkg::CFG_POWER_UP_US, 16'd65535);
        cfg_write(rtwdf_pkg::CFG_PROGRAM_WAIT_US, 16'd65535);
        send_request(4'hF, 32'hFFFF_FFFF);
        send_request(4'h0, 32'h0000_0000);
        wait_drain();
        // Zero timings must pass through as zero-length parts.
        cfg_write(rtwdf_pkg::CFG_WRITE_OPCODE, 16'd0);
        cfg_write_timings(16'd0);
        send_request(4'h3, 32'h8000_0001);
        send_request(4'hC, 32'h7FFF_FFFE);
        wait_drain();
        // Values wider than a register keep only its low bits.
        cfg_write(rtwdf_pkg::CFG_WRITE_OPCODE, 16'hFFFD);
        cfg_write_timings(16'hF00F);
        send_request(4'h9, $urandom);
        wait_drain();
        // Writes to indexes past the register list change nothing.
        cfg_write(8'd8, 16'hFFFF);
        cfg_write(8'd255, 16'h0000);
        cfg_write(cfg_index_t'($urandom_range(255, 9)), cfg_data_t'($urandom_range(65535)));
        send_request(4'h6, $urandom);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        wait_drain();
        for (int i = 0; i < 8; i++) cfg_write(cfg_index_t'(i), pick_reg_value());
        cfg_write(cfg_index_t'($urandom_range(255, 8)), cfg_data_t'($urandom_range(65535)));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            send_request(4'($urandom_range(15)), pick_word_value());
            if ($urandom_range(29) == 0) wait_drain();
        end
        wait_drain();
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cur_opcode     = rtwdf_pkg::RST_WRITE_OPCODE;
        cur_one_on     = rtwdf_pkg::RST_ONE_BIT_ON_US;
        cur_zero_off   = rtwdf_pkg::RST_ZERO_BIT_OFF_US;
        cur_zero_on    = rtwdf_pkg::RST_ZERO_BIT_ON_US;
        cur_stop_off   = rtwdf_pkg::RST_STOP_GAP_OFF_US;
        cur_stop_on    = rtwdf_pkg::RST_STOP_GAP_ON_US;
        cur_power_on   = rtwdf_pkg::RST_POWER_UP_US;
        cur_program_on = rtwdf_pkg::RST_PROGRAM_WAIT_US;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_every_opcode();
        test_timing_extremes();
        test_random_traffic(110, 0, 0);
        test_random_traffic(100, 84, 0);
        test_random_traffic(100, 0, 84);
        test_random_traffic(120, 38, 38);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drain();
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && segments_due.size() == 0) begin
            $display("PASS rfid_tag_write_downlink_framer");
        end else begin
            $display("FAIL rfid_tag_write_downlink_framer");
        end
        $finish;
    end

endmodule
